// ----- rtl/pixel_channel_converter_defines.svh -----
// assertion macros for the rtl
`ifndef PIXEL_CHANNEL_CONVERTER_DEFINES_SVH
`define PIXEL_CHANNEL_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel_channel_converter: check failed");

// next-cycle implication, sampled on clk, off during reset
`define PCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel_channel_converter: check failed");

`endif

// ----- rtl/pcc_pkg.sv -----
`timescale 1ns / 1ps

package pcc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CH_W      = 3;
	localparam int CFG_IDX_W = 2;
	localparam int LUMA_W    = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = 2'd2;

	// channel count codes
	localparam logic [CH_W-1:0] CH_GREY       = 3'd1;
	localparam logic [CH_W-1:0] CH_GREY_ALPHA = 3'd2;
	localparam logic [CH_W-1:0] CH_RGB        = 3'd3;
	localparam logic [CH_W-1:0] CH_RGBA       = 3'd4;

	localparam logic MODE_8BIT  = 1'b0;
	localparam logic MODE_16BIT = 1'b1;

	localparam logic [LUMA_W-1:0]   LUMA_R   = 24'd77;
	localparam logic [LUMA_W-1:0]   LUMA_G   = 24'd150;
	localparam logic [LUMA_W-1:0]   LUMA_B   = 24'd29;
	localparam logic [SAMPLE_W-1:0] OPAQUE8  = 16'h00ff;
	localparam logic [SAMPLE_W-1:0] OPAQUE16 = 16'hffff;

	typedef struct packed {
		logic [SAMPLE_W-1:0] in_sample0;
		logic [SAMPLE_W-1:0] in_sample1;
		logic [SAMPLE_W-1:0] in_sample2;
		logic [SAMPLE_W-1:0] in_sample3;
		logic                in_last;
	} pcc_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_sample0;
		logic [SAMPLE_W-1:0] out_sample1;
		logic [SAMPLE_W-1:0] out_sample2;
		logic [SAMPLE_W-1:0] out_sample3;
		logic                out_last;
	} pcc_out_t;

	typedef struct packed {
		logic [CH_W-1:0] in_channels;
		logic [CH_W-1:0] dst_channels;
		logic            sample_mode;
	} pcc_cfg_t;

endpackage

// ----- rtl/pcc_luma.sv -----
`timescale 1ns / 1ps

module pcc_luma (
	input  logic [pcc_pkg::SAMPLE_W-1:0] red,
	input  logic [pcc_pkg::SAMPLE_W-1:0] green,
	input  logic [pcc_pkg::SAMPLE_W-1:0] blue,
	input  logic [pcc_pkg::SAMPLE_W-1:0] mask,
	output logic [pcc_pkg::SAMPLE_W-1:0] luma
);

	logic [pcc_pkg::LUMA_W-1:0] sum;

	// weights add to 256, so the sum fits in 24 bits
	assign sum = pcc_pkg::LUMA_W'(red)   * pcc_pkg::LUMA_R
	           + pcc_pkg::LUMA_W'(green) * pcc_pkg::LUMA_G
	           + pcc_pkg::LUMA_W'(blue)  * pcc_pkg::LUMA_B;

	assign luma = sum[pcc_pkg::LUMA_W-1:pcc_pkg::LUMA_W-pcc_pkg::SAMPLE_W] & mask;

endmodule

// ----- rtl/pcc_map.sv -----
`timescale 1ns / 1ps

module pcc_map (
	input  pcc_pkg::pcc_cfg_t cfg,
	input  pcc_pkg::pcc_in_t  pixel,
	output pcc_pkg::pcc_out_t result
);

	logic [pcc_pkg::SAMPLE_W-1:0] mask;
	logic [pcc_pkg::SAMPLE_W-1:0] s0, s1, s2, s3;
	logic [pcc_pkg::SAMPLE_W-1:0] d0, d1, d2, d3;
	logic [pcc_pkg::SAMPLE_W-1:0] grey_alpha, rgb_alpha;
	logic [pcc_pkg::SAMPLE_W-1:0] y;
	logic [pcc_pkg::CH_W-1:0]     ic, oc;
	logic                         supported;

	assign mask = (cfg.sample_mode == pcc_pkg::MODE_16BIT) ? pcc_pkg::OPAQUE16
	                                                       : pcc_pkg::OPAQUE8;
	assign s0 = pixel.in_sample0 & mask;
	assign s1 = pixel.in_sample1 & mask;
	assign s2 = pixel.in_sample2 & mask;
	assign s3 = pixel.in_sample3 & mask;
	assign ic = cfg.in_channels;
	assign oc = cfg.dst_channels;

	assign supported = (ic >= pcc_pkg::CH_GREY) && (ic <= pcc_pkg::CH_RGBA)
	                && (oc >= pcc_pkg::CH_GREY) && (oc <= pcc_pkg::CH_RGBA);

	// missing alpha reads as opaque, which equals the sample mask
	assign grey_alpha = (ic == pcc_pkg::CH_GREY_ALPHA) ? s1 : mask;
	assign rgb_alpha  = (ic == pcc_pkg::CH_RGBA) ? s3 : mask;

	pcc_luma u_luma (
		.red   (s0),
		.green (s1),
		.blue  (s2),
		.mask  (mask),
		.luma  (y)
	);

	always_comb begin
		d0 = '0;
		d1 = '0;
		d2 = '0;
		d3 = '0;
		if (supported) begin
			if (ic == oc) begin
				d0 = s0;
				if (ic >= pcc_pkg::CH_GREY_ALPHA) d1 = s1;
				if (ic >= pcc_pkg::CH_RGB) d2 = s2;
				if (ic == pcc_pkg::CH_RGBA) d3 = s3;
			end else if (ic <= pcc_pkg::CH_GREY_ALPHA) begin
				d0 = s0;
				if (oc == pcc_pkg::CH_GREY_ALPHA) begin
					d1 = grey_alpha;
				end else if (oc >= pcc_pkg::CH_RGB) begin
					d1 = s0;
					d2 = s0;
					if (oc == pcc_pkg::CH_RGBA) d3 = grey_alpha;
				end
			end else begin
				if (oc <= pcc_pkg::CH_GREY_ALPHA) begin
					d0 = y;
					if (oc == pcc_pkg::CH_GREY_ALPHA) d1 = rgb_alpha;
				end else begin
					d0 = s0;
					d1 = s1;
					d2 = s2;
					if (oc == pcc_pkg::CH_RGBA) d3 = rgb_alpha;
				end
			end
		end
	end

	assign result.out_sample0 = d0;
	assign result.out_sample1 = d1;
	assign result.out_sample2 = d2;
	assign result.out_sample3 = d3;
	assign result.out_last    = pixel.in_last;

endmodule

// ----- rtl/pixel_channel_converter.sv -----
`timescale 1ns / 1ps
// channel   | signals                         | handshake
// ----------+---------------------------------+--------------------------------
// pixel in  | start, busy, pixel_in           | taken when start && !busy
// pixel out | done, pixel_out                 | one-cycle strobe, no backpressure
// config    | cfg_we, cfg_index, cfg_data     | written when cfg_we is high
//
// one pixel per cycle; each transaction shows on pixel_out once it has passed through
// the input register and the result register around the luma multiply-add.
// busy stays low: nothing in the path can hold a pixel back.
// arst_n clears the valid pipe and sets in/out channels to 4 and 8-bit mode.
// the user must write config only while no pixel is in flight; the block does not enforce it.

`include "pixel_channel_converter_defines.svh"

module pixel_channel_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pcc_pkg::pcc_in_t               pixel_in,
	output logic                           done,
	output pcc_pkg::pcc_out_t              pixel_out,
	input  logic                           cfg_we,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcc_pkg::CH_W-1:0]       cfg_data
);

	pcc_pkg::pcc_cfg_t cfg_q;
	pcc_pkg::pcc_in_t  pixel_s1;
	pcc_pkg::pcc_out_t pixel_s2;
	pcc_pkg::pcc_out_t result;
	logic              valid_s1;
	logic              valid_s2;
	logic              accept;
	logic              hi_zero;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels  <= pcc_pkg::CH_RGBA;
			cfg_q.dst_channels <= pcc_pkg::CH_RGBA;
			cfg_q.sample_mode  <= pcc_pkg::MODE_8BIT;
		end else if (cfg_we) begin
			case (cfg_index)
				pcc_pkg::CFG_IN_CHANNELS:  cfg_q.in_channels  <= cfg_data;
				pcc_pkg::CFG_OUT_CHANNELS: cfg_q.dst_channels <= cfg_data;
				pcc_pkg::CFG_SAMPLE_MODE:  cfg_q.sample_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel_in;
		end
		if (valid_s1) begin
			pixel_s2 <= result;
		end
	end

	pcc_map u_map (
		.cfg    (cfg_q),
		.pixel  (pixel_s1),
		.result (result)
	);

	assign done      = valid_s2;
	assign pixel_out = pixel_s2;

	assign hi_zero = (pixel_out.out_sample0[15:8] == 8'h00)
	              && (pixel_out.out_sample1[15:8] == 8'h00)
	              && (pixel_out.out_sample2[15:8] == 8'h00)
	              && (pixel_out.out_sample3[15:8] == 8'h00);

	`PCC_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1)
	`PCC_ASSERT_NEXT(a_s1_gives_done, valid_s1, done)
	`PCC_ASSERT_NEXT(a_no_spurious_done, !valid_s1, !done)
	`PCC_ASSERT_SAME(a_narrow_8bit, done && $past(cfg_q.sample_mode == pcc_pkg::MODE_8BIT), hi_zero)

endmodule
